@@ rtl/qsps_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qsps_pkg: shared types and constants of the query string pair splitter
// Result codes, character codes, and the result bundle that travels from
// the front classifier through the queue to the result sequencer.
// ----------------------------------------------------------------------------
package qsps_pkg;

    // result kinds
    localparam logic [1:0] KIND_KEY      = 2'd0;
    localparam logic [1:0] KIND_VALUE    = 2'd1;
    localparam logic [1:0] KIND_RESTART  = 2'd2;
    localparam logic [1:0] KIND_PAIR_END = 2'd3;

    // separator characters
    localparam logic [7:0] CHAR_AMP = 8'h26;
    localparam logic [7:0] CHAR_EQ  = 8'h3D;
    localparam logic [7:0] CHAR_PCT = 8'h25;

    // one result as seen on the output ports
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       has_value;
        logic       done;
    } t_result;

    // all results caused by one input byte, slot 0 first
    typedef struct packed {
        logic [1:0]        last_idx;
        t_result [3:0]     res;
    } t_bundle;

endpackage
`default_nettype wire

@@ rtl/qsps_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qsps_front: byte classifier
// Tracks escape and key/value state and turns each accepted byte into a
// bundle of zero to four results, pushed into the result queue when not empty.
// ----------------------------------------------------------------------------
module qsps_front import qsps_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_last,
    output logic            o_q_push,
    output t_bundle         o_q_data
);

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_PCT,
        ESC_DIGIT
    } t_esc_state;

    t_esc_state    r_esc, n_esc;
    logic [7:0]    r_held, n_held;
    logic          r_inv, n_inv;

    logic [4:0]    v_hex;
    logic [4:0]    v_hi;
    logic          v_plain;
    logic [2:0]    v_idx;
    t_result [3:0] v_res;

    // hex digit decode: bit 4 flags a valid digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        return r;
    endfunction

    function automatic t_result mk_res(input logic [1:0] kind, input logic [7:0] data,
                                       input logic hasv, input logic done);
        t_result r;
        r.kind      = kind;
        r.data      = data;
        r.has_value = hasv;
        r.done      = done;
        return r;
    endfunction

    // classify the byte and build its result bundle
    always_comb begin
        v_hex   = hex_val(i_in_byte);
        v_hi    = hex_val(r_held);
        v_idx   = 3'd0;
        v_res   = '0;
        v_plain = 1'b0;
        n_esc   = r_esc;
        n_held  = r_held;
        n_inv   = r_inv;

        unique case (r_esc)
            ESC_PCT: begin
                if (v_hex[4] && !i_in_last) begin
                    n_held = i_in_byte;
                    n_esc  = ESC_DIGIT;
                end else begin
                    v_res[v_idx[1:0]] = mk_res(n_inv ? KIND_VALUE : KIND_KEY, CHAR_PCT,
                                               1'b0, 1'b0);
                    v_idx   = v_idx + 3'd1;
                    n_esc   = ESC_IDLE;
                    v_plain = 1'b1;
                end
            end
            ESC_DIGIT: begin
                n_esc = ESC_IDLE;
                if (v_hex[4] && v_hi[4]) begin
                    v_res[v_idx[1:0]] = mk_res(n_inv ? KIND_VALUE : KIND_KEY,
                                               {v_hi[3:0], v_hex[3:0]}, 1'b0, 1'b0);
                    v_idx = v_idx + 3'd1;
                    if (i_in_last) begin
                        v_res[v_idx[1:0]] = mk_res(KIND_PAIR_END, 8'd0, n_inv, 1'b1);
                        v_idx = v_idx + 3'd1;
                        n_inv = 1'b0;
                    end
                end else begin
                    v_res[v_idx[1:0]] = mk_res(n_inv ? KIND_VALUE : KIND_KEY, CHAR_PCT,
                                               1'b0, 1'b0);
                    v_idx = v_idx + 3'd1;
                    v_res[v_idx[1:0]] = mk_res(n_inv ? KIND_VALUE : KIND_KEY, r_held,
                                               1'b0, 1'b0);
                    v_idx   = v_idx + 3'd1;
                    v_plain = 1'b1;
                end
            end
            default: begin
                n_esc   = ESC_IDLE;
                v_plain = 1'b1;
            end
        endcase

        // byte handled with no escape pending
        if (v_plain) begin
            priority if (i_in_byte == CHAR_AMP) begin
                v_res[v_idx[1:0]] = mk_res(KIND_PAIR_END, 8'd0, n_inv, 1'b0);
                v_idx = v_idx + 3'd1;
                n_inv = 1'b0;
            end else if (i_in_byte == CHAR_EQ) begin
                v_res[v_idx[1:0]] = mk_res(KIND_RESTART, 8'd0, 1'b0, 1'b0);
                v_idx = v_idx + 3'd1;
                n_inv = 1'b1;
            end else if (i_in_byte == CHAR_PCT && !i_in_last) begin
                n_esc = ESC_PCT;
            end else begin
                v_res[v_idx[1:0]] = mk_res(n_inv ? KIND_VALUE : KIND_KEY, i_in_byte,
                                           1'b0, 1'b0);
                v_idx = v_idx + 3'd1;
            end
            if (i_in_last) begin
                v_res[v_idx[1:0]] = mk_res(KIND_PAIR_END, 8'd0, n_inv, 1'b1);
                v_idx = v_idx + 3'd1;
                n_inv = 1'b0;
                n_esc = ESC_IDLE;
            end
        end
    end

    // queue push
    assign o_q_push          = i_accept && (v_idx != 3'd0);
    assign o_q_data.last_idx = 2'(v_idx - 3'd1);
    assign o_q_data.res      = v_res;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc  <= ESC_IDLE;
            r_held <= 8'd0;
            r_inv  <= 1'b0;
        end else if (i_accept) begin
            r_esc  <= n_esc;
            r_held <= n_held;
            r_inv  <= n_inv;
        end
    end

`ifndef ASSERT_OFF
    // a pending digit is always a valid hex digit
    a_held_hex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_esc == ESC_DIGIT) |-> v_hi[4])
        else $error("escape digit held without a valid hex digit");
`endif

endmodule
`default_nettype wire

@@ rtl/qsps_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qsps_fifo: result bundle queue
// Short flip-flop queue between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module qsps_fifo import qsps_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_bundle i_data,
    input  wire logic    i_pop,
    output t_bundle      o_data,
    output logic         o_full,
    output logic         o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_bundle       r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          v_wr, v_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign v_wr    = i_push && !o_full;
    assign v_rd    = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (v_wr) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (v_wr) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (v_rd) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + CW'(v_wr) - CW'(v_rd);
        end
    end

endmodule
`default_nettype wire

@@ rtl/qsps_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qsps_back: result sequencer
// Takes one bundle at a time from the queue and hands out its results,
// one per transfer, flagging the last result of each bundle.
// ----------------------------------------------------------------------------
module qsps_back import qsps_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_bundle i_q_data,
    input  wire logic    i_q_empty,
    output logic         o_q_pop,
    input  wire logic    i_pop,
    output logic         o_empty,
    output logic [1:0]   o_out_kind,
    output logic [7:0]   o_out_byte,
    output logic         o_pair_has_value,
    output logic         o_query_done,
    output logic         o_run_last
);

    t_bundle    r_cur;
    logic       r_valid;
    logic [1:0] r_idx;
    t_result    v_res;
    logic       v_at_last;
    logic       v_take;

    assign v_res     = r_cur.res[r_idx];
    assign v_at_last = (r_idx == r_cur.last_idx);
    assign v_take    = r_valid && i_pop;
    assign o_q_pop   = !i_q_empty && (!r_valid || (v_take && v_at_last));

    // result ports
    assign o_empty          = !r_valid;
    assign o_out_kind       = v_res.kind;
    assign o_out_byte       = v_res.data;
    assign o_pair_has_value = v_res.has_value;
    assign o_query_done     = v_res.done;
    assign o_run_last       = v_at_last;

    // bundle load
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur <= i_q_data;
        end
    end

    // slot walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (v_take) begin
            if (v_at_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_idx <= r_cur.last_idx))
        else $error("result slot beyond end of bundle");
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && o_query_done) |-> (o_run_last && (o_out_kind == KIND_PAIR_END)))
        else $error("query end is not the closing pair end of its byte");
    a_flags_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (o_out_kind != KIND_PAIR_END)) |-> (!o_pair_has_value && !o_query_done))
        else $error("pair flags set on a non pair-end result");
`endif

endmodule
`default_nettype wire

@@ rtl/query_string_pair_splitter_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// query_string_pair_splitter_unit: streaming query string pair splitter
// Splits a url-encoded query string into key bytes, value bytes, value
// restarts and pair ends, decoding percent escapes on the way.
// ----------------------------------------------------------------------------
// channel  direction  handshake      payload
// input    in         push / full    i_in_byte, i_in_last
// result   out        empty / pop    o_out_kind, o_out_byte, o_pair_has_value,
//                                    o_query_done, o_run_last
//
// A byte is accepted every cycle while the bundle queue has room; each byte
// yields zero to four results, delivered one transfer per cycle by the back
// end while pop is high and results are waiting.
// A byte's first result shows once the queue has handed its bundle to the back end.
// full rises once four bundles wait behind the one being handed out.
// Synchronous active-low reset clears parser state, queue and sequencer.
// ----------------------------------------------------------------------------
module query_string_pair_splitter_unit import qsps_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_last,
    output logic            empty,
    input  wire logic       pop,
    output logic [1:0]      o_out_kind,
    output logic [7:0]      o_out_byte,
    output logic            o_pair_has_value,
    output logic            o_query_done,
    output logic            o_run_last
);

    logic    w_accept;
    logic    w_q_push, w_q_pop, w_q_full, w_q_empty;
    t_bundle w_q_in, w_q_out;

    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    // classifier
    qsps_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .o_q_push  (w_q_push),
        .o_q_data  (w_q_in)
    );

    // bundle queue
    qsps_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .i_pop   (w_q_pop),
        .o_data  (w_q_out),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    // result sequencer
    qsps_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_data         (w_q_out),
        .i_q_empty        (w_q_empty),
        .o_q_pop          (w_q_pop),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_out_kind       (o_out_kind),
        .o_out_byte       (o_out_byte),
        .o_pair_has_value (o_pair_has_value),
        .o_query_done     (o_query_done),
        .o_run_last       (o_run_last)
    );

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of query_string_pair_splitter_unit
// Feeds directed and random query strings through the byte input queue and
// checks every result against a cycle-free model of the splitter, with random
// gaps on both sides, one long receiver hold-off and drain pauses.
// ----------------------------------------------------------------------------
module tb;
    import qsps_pkg::*;

    // escape decoder stages
    localparam logic [1:0] ESC_IDLE  = 2'd0;
    localparam logic [1:0] ESC_PCT   = 2'd1;
    localparam logic [1:0] ESC_DIGIT = 2'd2;

    localparam int RANDOM_ITEMS = 270;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_LEN     = 300;
    localparam int DRAIN_AT     = 175;
    localparam int MAX_PER_BYTE = 4;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       has_value;
        logic       done;
        logic       run_last;
    } t_split_result;

    typedef struct {
        logic [7:0] data;
        logic       last;
        int         gap;
        bit         drain;
    } t_query_byte;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_in_last = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [1:0] o_out_kind;
    logic [7:0] o_out_byte;
    logic       o_pair_has_value;
    logic       o_query_done;
    logic       o_run_last;

    t_query_byte   query_bytes_q[$];
    t_split_result split_results_q[$];

    // splitter model state
    logic [1:0] esc_stage = ESC_IDLE;
    logic [7:0] held_hex = 8'h00;
    logic       in_value = 1'b0;
    int         emit_cnt;

    int  n_errors = 0;
    int  n_results = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  calm_left = 0;
    int  hold_left = 0;
    bit  hold_done = 0;
    bit  send_calm = 0;
    bit  drain_next = 0;

    query_string_pair_splitter_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_in_byte        (i_in_byte),
        .i_in_last        (i_in_last),
        .empty            (empty),
        .pop              (pop),
        .o_out_kind       (o_out_kind),
        .o_out_byte       (o_out_byte),
        .o_pair_has_value (o_pair_has_value),
        .o_query_done     (o_query_done),
        .o_run_last       (o_run_last)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // splitter model
    // ------------------------------------------------------------------------
    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        return -1;
    endfunction

    task automatic put_result(input logic [1:0] kind, input logic [7:0] data,
                              input logic has_value, input logic done);
        t_split_result r;
        if (emit_cnt >= MAX_PER_BYTE) return;
        r.kind      = kind;
        r.data      = data;
        r.has_value = has_value;
        r.done      = done;
        r.run_last  = 1'b0;
        split_results_q.push_back(r);
        emit_cnt++;
    endtask

    task automatic put_data(input logic [7:0] data);
        put_result(in_value ? KIND_VALUE : KIND_KEY, data, 1'b0, 1'b0);
    endtask

    task automatic close_pair(input logic done);
        put_result(KIND_PAIR_END, 8'h00, in_value, done);
        in_value = 1'b0;
    endtask

    // byte with no escape pending
    task automatic plain_char(input logic [7:0] c, input logic last);
        if (c == CHAR_AMP) begin
            close_pair(1'b0);
        end else if (c == CHAR_EQ) begin
            put_result(KIND_RESTART, 8'h00, 1'b0, 1'b0);
            in_value = 1'b1;
        end else if (c == CHAR_PCT) begin
            if (last) put_data(c);
            else esc_stage = ESC_PCT;
        end else begin
            put_data(c);
        end
        if (last) begin
            close_pair(1'b1);
            esc_stage = ESC_IDLE;
        end
    endtask

    // all results caused by one accepted byte
    task automatic split_byte(input logic [7:0] c, input logic last);
        int hv;
        int hi;
        emit_cnt = 0;
        hv = hex_digit(c);
        case (esc_stage)
            ESC_PCT: begin
                if (hv >= 0 && !last) begin
                    held_hex  = c;
                    esc_stage = ESC_DIGIT;
                end else begin
                    put_data(CHAR_PCT);
                    esc_stage = ESC_IDLE;
                    plain_char(c, last);
                end
            end
            ESC_DIGIT: begin
                hi = hex_digit(held_hex);
                esc_stage = ESC_IDLE;
                if (hv >= 0 && hi >= 0) begin
                    put_data(8'(hi * 16 + hv));
                    if (last) close_pair(1'b1);
                end else begin
                    put_data(CHAR_PCT);
                    put_data(held_hex);
                    plain_char(c, last);
                end
            end
            default: begin
                esc_stage = ESC_IDLE;
                plain_char(c, last);
            end
        endcase
        if (emit_cnt > 0) split_results_q[split_results_q.size() - 1].run_last = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 10) return 8'("0" + n);
        if ($urandom_range(0, 1) == 0) return 8'("a" + n - 10);
        return 8'("A" + n - 10);
    endfunction

    task automatic push_item(input logic [7:0] b);
        t_query_byte q;
        q.data  = b;
        q.last  = 1'b0;
        q.gap   = send_calm ? 0 : rand_gap();
        q.drain = drain_next;
        drain_next = 0;
        query_bytes_q.push_back(q);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_item(s[i]);
    endtask

    task automatic end_query();
        query_bytes_q[query_bytes_q.size() - 1].last = 1'b1;
    endtask

    // one key or value character, plain or percent-encoded
    task automatic push_field_char();
        string      plain;
        logic [7:0] v;
        plain = "abcxyzXYZ019-_.~+";
        if ($urandom_range(0, 9) < 7) begin
            push_item(plain[$urandom_range(0, plain.len() - 1)]);
        end else begin
            v = 8'($urandom_range(0, 255));
            push_item(CHAR_PCT);
            push_item(hex_char(v[7:4]));
            push_item(hex_char(v[3:0]));
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: offers pending bytes, predicts results at each transfer
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit offer;
        if (!i_rst_n) begin
            push      <= 1'b0;
            i_in_byte <= 8'h00;
            i_in_last <= 1'b0;
            esc_stage = ESC_IDLE;
            held_hex  = 8'h00;
            in_value  = 1'b0;
        end else begin
            if (push && !full) begin
                split_byte(i_in_byte, i_in_last);
                void'(query_bytes_q.pop_front());
                if (query_bytes_q.size() > 0) gap_left = query_bytes_q[0].gap;
            end
            // hold the offer while the block is full
            if (!(push && full)) begin
                offer = 0;
                if (query_bytes_q.size() > 0) begin
                    if (gap_left > 0) gap_left--;
                    else if (!query_bytes_q[0].drain || split_results_q.size() == 0)
                        offer = 1;
                end
                if (offer) begin
                    i_in_byte <= query_bytes_q[0].data;
                    i_in_last <= query_bytes_q[0].last;
                    push      <= 1'b1;
                end else begin
                    push      <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks each result transfer, stalls the result side
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_split_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (split_results_q.size() == 0) begin
                    $error("unexpected result: kind %0d byte %0h", o_out_kind, o_out_byte);
                    n_errors++;
                end else begin
                    want = split_results_q.pop_front();
                    if (o_out_kind !== want.kind) begin
                        $error("out_kind: expected %0d, actual %0d", want.kind, o_out_kind);
                        n_errors++;
                    end
                    if (o_out_byte !== want.data) begin
                        $error("out_byte: expected %0h, actual %0h", want.data, o_out_byte);
                        n_errors++;
                    end
                    if (o_pair_has_value !== want.has_value) begin
                        $error("pair_has_value: expected %0d, actual %0d",
                               want.has_value, o_pair_has_value);
                        n_errors++;
                    end
                    if (o_query_done !== want.done) begin
                        $error("query_done: expected %0d, actual %0d", want.done, o_query_done);
                        n_errors++;
                    end
                    if (o_run_last !== want.run_last) begin
                        $error("run_last: expected %0d, actual %0d", want.run_last, o_run_last);
                        n_errors++;
                    end
                end
                n_results++;
            end
            // one long hold-off so the block backs up into its input
            if (n_results == HOLD_AT && !hold_done) begin
                hold_left = HOLD_LEN;
                hold_done = 1;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                if (calm_left > 0) calm_left--;
                else if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(30, 80);
                else stall_left = rand_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial begin
        int n_directed;
        int sel;
        int start;
        int n;
        int m;

        // escapes decoding to separators and zero, repeated '=', trailing '&'
        push_text("k%3D%26%00=v=w&");
        end_query();
        // lone percent sign at the end
        push_item(CHAR_PCT);
        end_query();
        // escape cut by the end after one digit
        push_text("%4");
        end_query();
        // broken escapes, raw zero and all-ones bytes
        push_text("%z%4g");
        push_item(8'h00);
        push_item(8'hFF);
        end_query();
        n_directed = query_bytes_q.size();

        // random queries, mostly well formed
        drain_next = 1;
        while (query_bytes_q.size() < n_directed + RANDOM_ITEMS) begin
            if (query_bytes_q.size() >= n_directed + DRAIN_AT &&
                query_bytes_q.size() < n_directed + DRAIN_AT + 12)
                drain_next = 1;
            send_calm = ($urandom_range(0, 4) == 0);
            start = query_bytes_q.size();
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                n = $urandom_range(1, 4);
                for (int p = 0; p < n; p++) begin
                    if (p > 0) push_item(CHAR_AMP);
                    m = $urandom_range(0, 4);
                    for (int k = 0; k < m; k++) push_field_char();
                    if ($urandom_range(0, 4) != 0) begin
                        push_item(CHAR_EQ);
                        m = $urandom_range(0, 4);
                        for (int k = 0; k < m; k++) push_field_char();
                        if ($urandom_range(0, 4) == 0) begin
                            push_item(CHAR_EQ);
                            m = $urandom_range(0, 3);
                            for (int k = 0; k < m; k++) push_field_char();
                        end
                    end
                end
                if ($urandom_range(0, 6) == 0) push_item(CHAR_AMP);
                if (query_bytes_q.size() == start) push_item("x");
            end else if (sel < 9) begin
                // broken escapes mixed with separators
                n = $urandom_range(1, 8);
                for (int k = 0; k < n; k++) begin
                    case ($urandom_range(0, 5))
                        0, 1: push_item(CHAR_PCT);
                        2: push_item(hex_char(4'($urandom_range(0, 15))));
                        3: push_item(CHAR_EQ);
                        4: push_item(CHAR_AMP);
                        default: push_item(8'($urandom_range(0, 255)));
                    endcase
                end
            end else begin
                // raw noise, with stray end marks
                n = $urandom_range(1, 8);
                for (int k = 0; k < n; k++) begin
                    push_item(8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 3) == 0) end_query();
                end
            end
            end_query();
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (query_bytes_q.size() != 0) @(posedge i_clk);
        while (split_results_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/qsps_pkg.sv
rtl/qsps_front.sv
rtl/qsps_fifo.sv
rtl/qsps_back.sv
rtl/query_string_pair_splitter_unit.sv
tb/sv/tb.sv
